[hdl/sorted_list_table_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sorted list table
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_TABLE_ASSERT_SVH
`define SORTED_LIST_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLT_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define SLT_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

[hdl/slt_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted list table package
// Field widths, operation codes and the beat types shared by the table
// and its sequencer.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int unsigned FUNC_W       = 2;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned INDEX_W      = 6;
  localparam int unsigned COUNT_W      = 7;
  localparam int unsigned CAPACITY_DEF = 64;

  // Data returned by a failed read and by every other operation.
  localparam logic signed [VALUE_W-1:0] DATA_NONE = '1;

  // Operation codes carried by the func field.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_READ   = 2'd2
  } slt_func_e;

  // One request beat as handed to the sequencer.
  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;
  } slt_req_t;

  // One result beat as handed back by the sequencer.
  typedef struct packed {
    logic                      ok;
    logic signed [VALUE_W-1:0] data;
    logic [COUNT_W-1:0]        count;
    logic                      empty;
  } slt_res_t;

endpackage

[hdl/sorted_list_table.sv]
// ----------------------------------------------------------------------------
// Sorted list table
// Ascending multiset of signed 32-bit values with insert, remove and
// read-by-rank operations.
// ----------------------------------------------------------------------------
// Usage: a request beat (func, value, index) is taken when in_valid_i is high
// and in_stall_o is low. Each request gives exactly one result beat (ok_o,
// data_o, count_o, empty_res_o), taken when out_valid_o is high and
// out_stall_i is low. One request is worked on at a time; in_stall_o stays
// high from acceptance until the result has moved into the output register.
// An insert walks down from the top entry and a remove walks up from the
// bottom; an insert into a full table, a read and an unused code need no walk.
// Each step of the walk is a registered read and then one compare or one move.
// If the receiver stalls, the held result beat waits in the output register,
// the next request is still taken, and its result waits in the sequencer.
// Reset empties the table at once; the entry memory needs no clearing pass.
module sorted_list_table
  import slt_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [FUNC_W-1:0]         func_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic [INDEX_W-1:0]        index_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      ok_o,
  output logic signed [VALUE_W-1:0] data_o,
  output logic [COUNT_W-1:0]        count_o,
  output logic                      empty_res_o
);

  logic     core_idle;
  logic     core_res_valid;
  logic     out_free;
  slt_req_t req;
  slt_res_t core_res;
  logic     out_valid_q;
  slt_res_t out_res_q;

  // Request beat into the sequencer.
  assign req.func    = func_i;
  assign req.value   = value_i;
  assign req.index   = index_i;
  assign in_stall_o  = !core_idle;

  // The output slot can take a result when empty or when its beat leaves.
  assign out_free = !out_valid_q || !out_stall_i;

  slt_core #(
    .CAPACITY (CAPACITY)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i),
    .req_i       (req),
    .out_free_i  (out_free),
    .idle_o      (core_idle),
    .res_valid_o (core_res_valid),
    .res_o       (core_res)
  );

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (core_res_valid) begin
      out_res_q <= core_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = out_res_q.ok;
  assign data_o      = out_res_q.data;
  assign count_o     = out_res_q.count;
  assign empty_res_o = out_res_q.empty;

endmodule

[hdl/slt_core.sv]
// ----------------------------------------------------------------------------
// Sorted list table sequencer
// Holds the entry memory and walks it one read or move per step, comparing
// each entry read against the captured value, to insert, remove or read an entry.
// ----------------------------------------------------------------------------
module slt_core
  import slt_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  slt_req_t req_i,
  input  logic     out_free_i,
  output logic     idle_o,
  output logic     res_valid_o,
  output slt_res_t res_o
);

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned ADDR_W = $clog2(CAPACITY);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_INS_RD  = 4'd1;
  localparam logic [3:0] ST_INS_CHK = 4'd2;
  localparam logic [3:0] ST_RM_RD   = 4'd3;
  localparam logic [3:0] ST_RM_CHK  = 4'd4;
  localparam logic [3:0] ST_SH_RD   = 4'd5;
  localparam logic [3:0] ST_SH_WR   = 4'd6;
  localparam logic [3:0] ST_GET_WT  = 4'd7;
  localparam logic [3:0] ST_DONE    = 4'd8;

  logic [3:0]                state_q, state_d;
  logic [CNT_W-1:0]          ptr_q, ptr_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic                      ok_q, ok_d;
  logic signed [VALUE_W-1:0] data_q, data_d;
  logic signed [VALUE_W-1:0] value_q;

  logic [VALUE_W-1:0]        mem [CAPACITY];
  logic signed [VALUE_W-1:0] rdata_q;
  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  logic signed [VALUE_W-1:0] mem_wdata;
  logic                      mem_re;
  logic [ADDR_W-1:0]         mem_raddr;

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // The operand value is captured with the request beat.
  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == ST_IDLE)) begin
      value_q <= req_i.value;
    end
  end

  // Sequencer next state. Insert walks down from the top, moving each entry
  // that is not smaller one place up. Remove scans up for the value and then
  // closes the gap by moving the entries above it one place down.
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    count_d     = count_q;
    ok_d        = ok_q;
    data_d      = data_q;
    mem_we      = 1'b0;
    mem_waddr   = ptr_q[ADDR_W-1:0];
    mem_wdata   = value_q;
    mem_re      = 1'b0;
    mem_raddr   = ptr_q[ADDR_W-1:0];
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ok_d   = 1'b0;
          data_d = DATA_NONE;
          case (req_i.func)
            FUNC_INSERT: begin
              if (count_q == CNT_W'(CAPACITY)) begin
                state_d = ST_DONE;
              end else begin
                ptr_d   = count_q;
                state_d = ST_INS_RD;
              end
            end
            FUNC_REMOVE: begin
              ptr_d   = '0;
              state_d = ST_RM_RD;
            end
            FUNC_READ: begin
              if (int'(req_i.index) < int'(count_q)) begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(req_i.index);
                state_d   = ST_GET_WT;
              end else begin
                state_d = ST_DONE;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_INS_RD: begin
        if (ptr_q == '0) begin
          mem_we  = 1'b1;
          ok_d    = 1'b1;
          count_d = count_q + 1'b1;
          state_d = ST_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(ptr_q - 1'b1);
          state_d   = ST_INS_CHK;
        end
      end

      ST_INS_CHK: begin
        mem_we = 1'b1;
        if (rdata_q < value_q) begin
          ok_d    = 1'b1;
          count_d = count_q + 1'b1;
          state_d = ST_DONE;
        end else begin
          mem_wdata = rdata_q;
          ptr_d     = ptr_q - 1'b1;
          state_d   = ST_INS_RD;
        end
      end

      ST_RM_RD: begin
        if (ptr_q == count_q) begin
          state_d = ST_DONE;
        end else begin
          mem_re  = 1'b1;
          state_d = ST_RM_CHK;
        end
      end

      ST_RM_CHK: begin
        if (rdata_q == value_q) begin
          state_d = ST_SH_RD;
        end else if (value_q < rdata_q) begin
          state_d = ST_DONE;
        end else begin
          ptr_d   = ptr_q + 1'b1;
          state_d = ST_RM_RD;
        end
      end

      ST_SH_RD: begin
        if ((ptr_q + 1'b1) >= count_q) begin
          ok_d    = 1'b1;
          count_d = count_q - 1'b1;
          state_d = ST_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(ptr_q + 1'b1);
          state_d   = ST_SH_WR;
        end
      end

      ST_SH_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q;
        ptr_d     = ptr_q + 1'b1;
        state_d   = ST_SH_RD;
      end

      ST_GET_WT: begin
        ok_d    = 1'b1;
        data_d  = rdata_q;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Walk pointer and pending result.
  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    ok_q   <= ok_d;
    data_q <= data_d;
  end

  assign idle_o      = (state_q == ST_IDLE);
  assign res_o.ok    = ok_q;
  assign res_o.data  = data_q;
  assign res_o.count = COUNT_W'(count_q);
  assign res_o.empty = (count_q == '0);

endmodule

[hdl/slt_checker.sv]
// ----------------------------------------------------------------------------
// Sorted list table checker
// Port-level checks on the result beats and the request flow, bound to
// the top level.
// ----------------------------------------------------------------------------
`include "sorted_list_table_assert.svh"

module slt_assert_checker
  import slt_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic                      ok_o,
  input logic signed [VALUE_W-1:0] data_o,
  input logic [COUNT_W-1:0]        count_o,
  input logic                      empty_res_o
);

  logic                             out_wait;
  logic [VALUE_W+COUNT_W+1:0]       out_beat;

  // A result beat that is offered and stalled, and its whole payload.
  assign out_wait = out_valid_o && out_stall_i;
  assign out_beat = {ok_o, data_o, count_o, empty_res_o};

  // A stalled result beat stays and keeps its payload.
  `SLT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_beat))

  // Once a request is taken, the block works on it alone.
  `SLT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // The empty flag agrees with the entry count.
  `SLT_ASSERT_IMPLY(a_empty_count, clk_i, rst_ni, out_valid_o, empty_res_o == (count_o == '0))

  // A failed operation never returns data.
  `SLT_ASSERT_IMPLY(a_fail_data, clk_i, rst_ni, out_valid_o && !ok_o, data_o == DATA_NONE)

  // The count never passes the capacity.
  `SLT_ASSERT_IMPLY(a_count_cap, clk_i, rst_ni, out_valid_o, int'(count_o) <= int'(CAPACITY))

endmodule

bind sorted_list_table slt_assert_checker #(
  .CAPACITY (CAPACITY)
) u_slt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .ok_o        (ok_o),
  .data_o      (data_o),
  .count_o     (count_o),
  .empty_res_o (empty_res_o)
);

[bench/slt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list table result checker
// Watches the request and result channels of the sorted list table. For every
// accepted request beat it updates its own sorted copy of the table, queues
// the expected result beat, and compares each accepted result beat against
// the oldest expectation, field by field.
// ----------------------------------------------------------------------------
module slt_checker
  import slt_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [FUNC_W-1:0]         func_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic [INDEX_W-1:0]        index_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic                      ok_i,
  input  logic signed [VALUE_W-1:0] data_i,
  input  logic [COUNT_W-1:0]        count_i,
  input  logic                      empty_res_i,
  output int unsigned               fail_count_o,
  output int unsigned               pending_o
);

  // Ascending copy of the table contents, duplicates kept side by side.
  logic signed [VALUE_W-1:0] sorted_vals[$];
  // Result beats still owed by the table, oldest first.
  slt_res_t                  owed_results[$];
  int unsigned               mismatch_cnt;

  // Applies one operation to the sorted copy and returns the result beat.
  function automatic slt_res_t apply_table_op(input logic [FUNC_W-1:0] func,
                                              input logic signed [VALUE_W-1:0] value,
                                              input logic [INDEX_W-1:0] index);
    slt_res_t res;
    int       pos;
    res.ok   = 1'b0;
    res.data = DATA_NONE;
    pos      = 0;
    case (func)
      FUNC_INSERT: begin
        // A full table refuses the value and stays as it is.
        if (sorted_vals.size() < CAPACITY) begin
          while (pos < sorted_vals.size() && sorted_vals[pos] < value) pos++;
          sorted_vals.insert(pos, value);
          res.ok = 1'b1;
        end
      end
      FUNC_REMOVE: begin
        // The first entry not below the value is the first equal one, if any.
        while (pos < sorted_vals.size() && sorted_vals[pos] < value) pos++;
        if (pos < sorted_vals.size() && sorted_vals[pos] == value) begin
          sorted_vals.delete(pos);
          res.ok = 1'b1;
        end
      end
      FUNC_READ: begin
        if (int'(index) < sorted_vals.size()) begin
          res.data = sorted_vals[index];
          res.ok   = 1'b1;
        end
      end
      default: begin
        // The spare code leaves the table alone and fails.
      end
    endcase
    res.count = COUNT_W'(sorted_vals.size());
    res.empty = (sorted_vals.size() == 0);
    return res;
  endfunction

  // Both channels are sampled at the clock edge, with the values held before it.
  always @(posedge clk_i or negedge rst_ni) begin
    slt_res_t exp_res;
    slt_res_t got_res;
    if (!rst_ni) begin
      sorted_vals.delete();
      owed_results.delete();
      mismatch_cnt = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        owed_results.push_back(apply_table_op(func_i, value_i, index_i));
      end
      if (out_valid_i && !out_stall_i) begin
        got_res.ok    = ok_i;
        got_res.data  = data_i;
        got_res.count = count_i;
        got_res.empty = empty_res_i;
        if (owed_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("[%0t] result beat with nothing expected: ok=%0b data=%0d count=%0d empty=%0b",
                     $realtime, got_res.ok, got_res.data, got_res.count, got_res.empty);
          end
        end else begin
          exp_res = owed_results.pop_front();
          if (got_res.ok !== exp_res.ok || got_res.data !== exp_res.data ||
              got_res.count !== exp_res.count || got_res.empty !== exp_res.empty) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("[%0t] result mismatch: expected ok=%0b data=%0d count=%0d empty=%0b",
                       $realtime, exp_res.ok, exp_res.data, exp_res.count, exp_res.empty);
              $display("[%0t]                  actual   ok=%0b data=%0d count=%0d empty=%0b",
                       $realtime, got_res.ok, got_res.data, got_res.count, got_res.empty);
            end
          end
        end
      end
      fail_count_o <= mismatch_cnt;
      pending_o    <= owed_results.size();
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list table testbench
// Drives insert, remove and read request beats into the sorted list table
// with random gaps and random result stalls. A directed opening covers the
// value extremes, duplicates, absent values, reads out of range and the spare
// operation code; random phases then fill the table to capacity and drain it.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
  import slt_pkg::*;

  localparam int unsigned TABLE_CAP   = CAPACITY_DEF;
  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam int unsigned DRAIN_WAIT  = 300;
  localparam int unsigned POOL_N      = 12;
  localparam int unsigned PHASE_LEN   = 125;
  localparam logic [FUNC_W-1:0]         FUNC_SPARE = 2'd3;
  localparam logic signed [VALUE_W-1:0] VAL_MIN    = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX    = 32'sh7fff_ffff;

  // Operation mix of one random phase.
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_e;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic [FUNC_W-1:0]         func_i      = FUNC_INSERT;
  logic signed [VALUE_W-1:0] value_i     = '0;
  logic [INDEX_W-1:0]        index_i     = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic                      ok_o;
  logic signed [VALUE_W-1:0] data_o;
  logic [COUNT_W-1:0]        count_o;
  logic                      empty_res_o;

  int unsigned               fail_count;
  int unsigned               pending;
  int unsigned               cycle_cnt   = 0;
  int unsigned               stall_run   = 0;
  bit                        in_calm     = 1'b0;
  logic signed [VALUE_W-1:0] value_pool[POOL_N];

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sorted_list_table #(
    .CAPACITY (TABLE_CAP)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .value_i     (value_i),
    .index_i     (index_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ok_o        (ok_o),
    .data_o      (data_o),
    .count_o     (count_o),
    .empty_res_o (empty_res_o)
  );

  slt_checker #(
    .CAPACITY (TABLE_CAP)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .func_i       (func_i),
    .value_i      (value_i),
    .index_i      (index_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ok_i         (ok_o),
    .data_i       (data_o),
    .count_i      (count_o),
    .empty_res_i  (empty_res_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Run-time guard.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result back-pressure: runs of free and stalled cycles, mostly short,
  // with calm stretches where no new stall run begins.
  always @(posedge clk_i) begin
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else if (cycle_cnt[11:9] == 3'd0 || pick < 55) begin
      out_stall_i <= 1'b0;
      stall_run   <= $urandom_range(0, 4);
    end else if (pick < 90) begin
      out_stall_i <= 1'b1;
      stall_run   <= $urandom_range(0, 3);
    end else begin
      out_stall_i <= 1'b1;
      stall_run   <= $urandom_range(10, 50);
    end
  end

  // Idle cycles after a request beat: none in calm stretches.
  function automatic int unsigned pick_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (in_calm || pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Pool values repeat often, so duplicates and successful removes are common.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 65) return value_pool[$urandom_range(0, POOL_N - 1)];
    return $urandom();
  endfunction

  // Presents one request beat, holds it until taken, then may idle a while.
  task automatic send_beat(input logic [FUNC_W-1:0] func,
                           input logic signed [VALUE_W-1:0] value,
                           input logic [INDEX_W-1:0] index);
    int unsigned gap;
    gap = pick_gap();
    in_valid_i <= 1'b1;
    func_i     <= func;
    value_i    <= value;
    index_i    <= index;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Sends one random request beat drawn from the given operation mix.
  task automatic send_random(input op_mix_e mix);
    int unsigned         pick;
    int unsigned         ins_lim;
    int unsigned         rem_lim;
    logic [FUNC_W-1:0]   func;
    logic [INDEX_W-1:0]  index;
    pick = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin ins_lim = 75; rem_lim = 85; end
      MIX_DRAIN: begin ins_lim = 15; rem_lim = 85; end
      default:   begin ins_lim = 40; rem_lim = 70; end
    endcase
    if (pick < ins_lim) begin
      func = FUNC_INSERT;
    end else if (pick < rem_lim) begin
      func = FUNC_REMOVE;
    end else if (pick < 97) begin
      func = FUNC_READ;
    end else begin
      func = FUNC_SPARE;
    end
    index = ($urandom_range(0, 1) != 0) ? INDEX_W'($urandom_range(0, 15)) : INDEX_W'($urandom());
    send_beat(func, pick_value(), index);
  endtask

  // Blocks until every owed result beat has come back.
  task automatic wait_results();
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Stimulus and verdict.
  initial begin
    op_mix_e phase_mix[6];
    phase_mix = '{MIX_FILL, MIX_EVEN, MIX_DRAIN, MIX_FILL, MIX_FILL, MIX_DRAIN};
    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    value_pool[2] = '0;
    value_pool[3] = -1;
    value_pool[4] = 1;
    for (int i = 5; i < POOL_N; i++) value_pool[i] = $urandom();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: failed reads at both index extremes, failed remove, spare code.
    send_beat(FUNC_READ, 0, 0);
    send_beat(FUNC_READ, 0, '1);
    send_beat(FUNC_REMOVE, 5, 0);
    send_beat(FUNC_SPARE, -1, '1);
    // Value extremes and a duplicate.
    send_beat(FUNC_INSERT, VAL_MAX, 0);
    send_beat(FUNC_INSERT, VAL_MIN, 0);
    send_beat(FUNC_INSERT, 0, 0);
    send_beat(FUNC_INSERT, -1, 0);
    send_beat(FUNC_INSERT, 0, 0);
    send_beat(FUNC_INSERT, 7, 0);
    // Reads at the ends of the order and one past the last entry.
    send_beat(FUNC_READ, 0, 0);
    send_beat(FUNC_READ, 0, 5);
    send_beat(FUNC_READ, 0, 6);
    // Absent values inside the stored range, and the spare code.
    send_beat(FUNC_REMOVE, 3, 0);
    send_beat(FUNC_REMOVE, 100, 0);
    send_beat(FUNC_REMOVE, -100, 0);
    send_beat(FUNC_SPARE, VAL_MIN, 0);
    // Remove one of the duplicates, then the extremes.
    send_beat(FUNC_REMOVE, 0, 0);
    send_beat(FUNC_REMOVE, VAL_MAX, 0);
    send_beat(FUNC_REMOVE, VAL_MIN, 0);
    send_beat(FUNC_READ, 0, 0);
    send_beat(FUNC_INSERT, -5, 0);
    // Drain back to an empty table.
    send_beat(FUNC_REMOVE, 0, 0);
    send_beat(FUNC_REMOVE, -1, 0);
    send_beat(FUNC_REMOVE, 7, 0);
    send_beat(FUNC_REMOVE, -5, 0);

    // Let the block run dry once before the random phases.
    in_valid_i <= 1'b0;
    wait_results();

    // Random phases: fill to capacity, mix, drain, fill past capacity again, drain.
    for (int p = 0; p < 6; p++) begin
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (n % 40 == 0) in_calm = ($urandom_range(0, 3) == 0);
        send_random(phase_mix[p]);
      end
    end
    in_valid_i <= 1'b0;

    wait_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
